[sv/pste_pkg.sv]
// pste_pkg: shared types and constants for the ptp source table engine
// no dependencies
package pste_pkg;

    localparam int MacW   = 48;
    localparam int StampW = 64;
    localparam int SeqW   = 16;
    localparam int MaskW  = 18;
    localparam logic [7:0] AccBase = 8'h20;
    localparam logic [7:0] AccTop  = 8'h31;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_ROUND   = 2'd1,
        KIND_TXSTAMP = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    localparam logic [3:0] MsgSync     = 4'd0;
    localparam logic [3:0] MsgFollowUp = 4'd8;
    localparam logic [3:0] MsgDelayRsp = 4'd9;
    localparam logic [3:0] MsgAnnounce = 4'd11;

    localparam logic ResSample  = 1'b0;
    localparam logic ResRequest = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SYNC,
        ST_FOLLOW,
        ST_DRSP,
        ST_ANNOUNCE,
        ST_TXSTAMP,
        ST_DELAY,
        ST_ROUND,
        ST_EMIT,
        ST_RESTART
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic scan_clr;   // reset scan index and flags
        logic scan_step;  // examine one slot
        logic sel_tx;     // use entry_index as working slot
        logic wr_sync;
        logic wr_follow;
        logic wr_drsp;
        logic wr_mac;
        logic wr_tx;
        logic wr_delay;
        logic round_step; // bump one slot in a delay round
        logic emit;       // load output register
        logic restart_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic frame_ok;
        logic scan_done;
        logic hit;
        logic free_found;
        logic [3:0] mtype;
        logic follow_ok;
        logic drsp_ok;
        logic announce_ok;
        logic tx_in_range;
        logic round_done;
        logic round_active;
        logic out_busy;
    } stat_t;

endpackage

[sv/pste_ctrl.sv]
// pste_ctrl: sequencer for the ptp source table engine
// depends on pste_pkg
module pste_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  pste_pkg::stat_t st,
    output pste_pkg::cmd_t  cmd
);
    import pste_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                unique case (kind_t'(st.kind))
                    KIND_FRAME:   state_next = st.frame_ok ? ST_SCAN : ST_IDLE;
                    KIND_ROUND:   state_next = ST_ROUND;
                    KIND_TXSTAMP: state_next = ST_TXSTAMP;
                    default:      state_next = ST_RESTART;
                endcase
            end
            ST_SCAN:
            begin
                if (st.hit || st.scan_done)
                begin
                    if (!st.hit)
                        state_next = ST_ANNOUNCE;
                    else if (st.mtype == MsgSync)
                        state_next = ST_SYNC;
                    else if (st.mtype == MsgFollowUp)
                        state_next = ST_FOLLOW;
                    else if (st.mtype == MsgDelayRsp)
                        state_next = ST_DRSP;
                    else
                        state_next = ST_IDLE;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            ST_SYNC:
            begin
                cmd.wr_sync = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FOLLOW:
            begin
                if (!st.follow_ok)
                    state_next = ST_IDLE;
                else if (!st.out_busy)
                begin
                    cmd.wr_follow = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DRSP:
            begin
                if (st.drsp_ok)
                begin
                    cmd.wr_drsp = 1'b1;
                    state_next = ST_DELAY;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_ANNOUNCE:
            begin
                if (st.announce_ok && st.free_found)
                    cmd.wr_mac = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TXSTAMP:
            begin
                cmd.sel_tx = 1'b1;
                if (st.tx_in_range)
                begin
                    cmd.wr_tx = 1'b1;
                    state_next = ST_DELAY;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_DELAY:
            begin
                cmd.wr_delay = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ROUND:
            begin
                if (st.round_done)
                    state_next = ST_IDLE;
                else if (!st.round_active)
                    cmd.round_step = 1'b1;
                else if (!st.out_busy)
                begin
                    cmd.round_step = 1'b1;
                    cmd.emit = 1'b1;
                end
            end
            ST_RESTART:
            begin
                cmd.restart_step = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[sv/pste_dp.sv]
// pste_dp: slot table, stamp arithmetic and output register
// depends on pste_pkg
module pste_dp #(
    parameter int SOURCE_SLOTS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pste_pkg::cmd_t              cmd,
    output pste_pkg::stat_t             st,
    input  logic [pste_pkg::MaskW-1:0]  mask,
    input  logic [1:0]                  kind,
    input  logic                        from_self,
    input  logic [47:0]                 source_mac,
    input  logic [3:0]                  ptp_version,
    input  logic [3:0]                  message_type,
    input  logic [15:0]                 sequence_number,
    input  logic signed [7:0]           log_interval,
    input  logic [7:0]                  clock_accuracy,
    input  logic [63:0]                 time_stamp,
    input  logic [2:0]                  entry_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        result_kind,
    output logic [2:0]                  slot,
    output logic [63:0]                 sample_local,
    output logic [63:0]                 sample_remote,
    output logic [15:0]                 request_sequence,
    output logic                        last
);
    import pste_pkg::*;

    localparam int IW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int CW = $clog2(SOURCE_SLOTS + 1);
    localparam logic [CW-1:0] Slots = CW'(SOURCE_SLOTS);

    // slot table, all reset to zero
    logic [MacW-1:0]   mac_reg   [SOURCE_SLOTS];
    logic [StampW-1:0] srx_reg   [SOURCE_SLOTS];
    logic [StampW-1:0] drx_reg   [SOURCE_SLOTS];
    logic [StampW-1:0] dtx_reg   [SOURCE_SLOTS];
    logic [StampW-1:0] stx_reg   [SOURCE_SLOTS];
    logic [31:0]       pd_reg    [SOURCE_SLOTS];
    logic [SeqW-1:0]   dseq_reg  [SOURCE_SLOTS];
    logic [SeqW-1:0]   sseq_reg  [SOURCE_SLOTS];
    logic [7:0]        rate_reg  [SOURCE_SLOTS];

    // captured input word
    logic [1:0]   kind_reg;
    logic         self_reg;
    logic [47:0]  mac_in_reg;
    logic [3:0]   ver_reg;
    logic [3:0]   mt_reg;
    logic [15:0]  seq_reg;
    logic [7:0]   li_reg;
    logic [7:0]   acc_reg;
    logic [63:0]  ts_reg;
    logic [2:0]   ei_reg;

    // scan state
    logic [CW-1:0] idx_reg;
    logic          hit_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [3:0]    nres_reg;
    logic          pend_last;

    logic [IW-1:0] cur;
    logic [IW-1:0] w;
    logic [63:0]   dsum;
    logic [7:0]    acc_off;
    logic          acc_ok;
    logic          nxt_found;

    // output register
    logic         ov_reg;
    logic         rk_reg;
    logic [2:0]   slot_reg;
    logic [63:0]  sl_reg;
    logic [63:0]  sr_reg;
    logic [15:0]  rs_reg;
    logic         last_reg;

    assign cur = idx_reg[IW-1:0];
    assign w   = cmd.sel_tx ? IW'(ei_reg) : cur;

    assign dsum = (srx_reg[cur] + drx_reg[cur]) - (dtx_reg[cur] + stx_reg[cur]);
    assign acc_off = acc_reg - AccBase;
    assign acc_ok  = (acc_reg >= AccBase) && (acc_reg <= AccTop) &&
                     mask[acc_off[4:0]];

    // look ahead for another active slot in the round
    always_comb
    begin
        nxt_found = 1'b0;
        for (int i = SOURCE_SLOTS - 1; i >= 0; i--)
        begin
            if (CW'(i) > idx_reg && mac_reg[i] != '0)
                nxt_found = 1'b1;
        end
    end

    always_comb
    begin
        st = '0;
        st.kind = kind_reg;
        st.frame_ok = !self_reg && ver_reg == 4'd2 && mac_in_reg != '0;
        st.scan_done = idx_reg >= Slots;
        st.hit = hit_reg;
        st.free_found = free_reg;
        st.mtype = mt_reg;
        st.follow_ok = sseq_reg[cur] == seq_reg && srx_reg[cur] != '0;
        st.drsp_ok = dseq_reg[cur] == seq_reg;
        st.announce_ok = mt_reg == MsgAnnounce && acc_ok;
        st.tx_in_range = {29'd0, ei_reg} < 32'(SOURCE_SLOTS);
        st.round_done = idx_reg >= Slots || nres_reg >= 4'd8;
        st.round_active = idx_reg < Slots && mac_reg[cur] != '0;
        st.out_busy = ov_reg && !out_ready;
    end

    // input capture and scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= '0;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            free_idx_reg <= '0;
            nres_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg <= kind;
                self_reg <= from_self;
                mac_in_reg <= source_mac;
                ver_reg <= ptp_version;
                mt_reg <= message_type;
                seq_reg <= sequence_number;
                li_reg <= log_interval;
                acc_reg <= clock_accuracy;
                ts_reg <= time_stamp;
                ei_reg <= entry_index;
            end
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
                free_reg <= 1'b0;
                nres_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                if (mac_reg[cur] == mac_in_reg)
                    hit_reg <= 1'b1;
                else
                    idx_reg <= idx_reg + 1'b1;
                if (mac_reg[cur] == '0 && !free_reg)
                begin
                    free_reg <= 1'b1;
                    free_idx_reg <= cur;
                end
            end
            if (cmd.round_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cmd.emit)
                    nres_reg <= nres_reg + 1'b1;
            end
            // keep the stamped slot as working slot for the delay step
            if (cmd.wr_tx)
                idx_reg <= CW'(ei_reg);
        end
    end

    assign pend_last = !nxt_found || nres_reg >= 4'd7;

    // slot table writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SOURCE_SLOTS; i++)
            begin
                mac_reg[i] <= '0;
                srx_reg[i] <= '0;
                drx_reg[i] <= '0;
                dtx_reg[i] <= '0;
                stx_reg[i] <= '0;
                pd_reg[i] <= '0;
                dseq_reg[i] <= '0;
                sseq_reg[i] <= '0;
                rate_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.wr_sync)
            begin
                rate_reg[cur] <= li_reg;
                sseq_reg[cur] <= seq_reg;
                srx_reg[cur] <= ts_reg;
            end
            if (cmd.wr_follow)
                stx_reg[cur] <= ts_reg;
            if (cmd.wr_drsp)
                drx_reg[cur] <= ts_reg;
            if (cmd.wr_mac)
                mac_reg[free_idx_reg] <= mac_in_reg;
            if (cmd.wr_tx)
                dtx_reg[w] <= ts_reg;
            if (cmd.wr_delay && srx_reg[cur] != '0 && drx_reg[cur] != '0 &&
                dtx_reg[cur] != '0 && stx_reg[cur] != '0)
                pd_reg[cur] <= dsum[32:1];
            if (cmd.emit && kind_reg == KIND_ROUND)
            begin
                dseq_reg[cur] <= dseq_reg[cur] + 1'b1;
                drx_reg[cur] <= '0;
                dtx_reg[cur] <= '0;
            end
            if (cmd.restart_step)
            begin
                for (int i = 0; i < SOURCE_SLOTS; i++)
                begin
                    srx_reg[i] <= '0;
                    drx_reg[i] <= '0;
                    dtx_reg[i] <= '0;
                    stx_reg[i] <= '0;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.emit)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            slot_reg <= 3'(cur);
            if (kind_reg == KIND_ROUND)
            begin
                rk_reg <= ResRequest;
                sl_reg <= '0;
                sr_reg <= '0;
                rs_reg <= dseq_reg[cur] + 1'b1;
                last_reg <= pend_last;
            end
            else
            begin
                rk_reg <= ResSample;
                sl_reg <= srx_reg[cur];
                sr_reg <= stx_reg[cur] + {32'd0, pd_reg[cur]};
                rs_reg <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    assign out_valid = ov_reg;
    assign result_kind = rk_reg;
    assign slot = slot_reg;
    assign sample_local = sl_reg;
    assign sample_remote = sr_reg;
    assign request_sequence = rs_reg;
    assign last = last_reg;

endmodule

[sv/ptp_source_table_timestamp_engine.sv]
// ptp_source_table_timestamp_engine: top level, apb register and glue
// depends on pste_pkg, pste_ctrl, pste_dp
//
// usage:
//   input channel (in_valid/in_ready) takes one event word: received frame,
//   delay round, transmit stamp or restart. output channel (out_valid/
//   out_ready) gives offset samples and delay requests, last marks the
//   final word of an event. the apb port holds accepted_accuracy_mask at 0.
// flow:
//   a frame walks the slot table one slot a cycle until its mac matches
//   or the table ends; a delay round steps through the slots and holds
//   while the output is stalled. one event is in work at a time, so a new
//   event word is taken only after the last one is through; the single
//   table scan sets the rate.
// reset:
//   all slots free and all stamps zero, mask set to 7.
// stall:
//   when out_ready is low the finished word waits in the output register
//   and the sequencer holds before loading the next result.
module ptp_source_table_timestamp_engine #(
    parameter int SOURCE_SLOTS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   kind,
    input  logic         from_self,
    input  logic [47:0]  source_mac,
    input  logic [3:0]   ptp_version,
    input  logic [3:0]   message_type,
    input  logic [15:0]  sequence_number,
    input  logic signed [7:0] log_interval,
    input  logic [7:0]   clock_accuracy,
    input  logic [63:0]  time_stamp,
    input  logic [2:0]   entry_index,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         result_kind,
    output logic [2:0]   slot,
    output logic [63:0]  sample_local,
    output logic [63:0]  sample_remote,
    output logic [15:0]  request_sequence,
    output logic         last
);
    import pste_pkg::*;

    localparam logic [2:0] AddrMask = 3'd0;

    logic [MaskW-1:0] mask_reg;
    cmd_t  cmd;
    stat_t st;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= MaskW'(7);
        else if (psel && penable && pwrite && paddr == AddrMask)
            mask_reg <= pwdata[MaskW-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == AddrMask) ? {14'd0, mask_reg} : 32'd0;

    pste_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    pste_dp #(
        .SOURCE_SLOTS (SOURCE_SLOTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .mask             (mask_reg),
        .kind             (kind),
        .from_self        (from_self),
        .source_mac       (source_mac),
        .ptp_version      (ptp_version),
        .message_type     (message_type),
        .sequence_number  (sequence_number),
        .log_interval     (log_interval),
        .clock_accuracy   (clock_accuracy),
        .time_stamp       (time_stamp),
        .entry_index      (entry_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .slot             (slot),
        .sample_local     (sample_local),
        .sample_remote    (sample_remote),
        .request_sequence (request_sequence),
        .last             (last)
    );

`ifndef NO_ASSERTIONS
    // output word never overwritten while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !cmd.emit)
        else $error("output word overwritten");

    // no input taken while a result is being built
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !in_ready)
        else $error("input accepted during emit");

    // samples always close their event
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == ResSample |-> last)
        else $error("sample without last");
`endif

endmodule
